### sv/hrs_pkg.sv
// Shared types, constants and the sRGB threshold table for the half-float pixel core.
package hrs_pkg;

    typedef logic [319:0]       t_wide;
    typedef logic [255:0][14:0] t_thr_tab;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        last;
    } t_pix;

    localparam logic [4:0]  ExpInfNan  = 5'd31;
    localparam logic [4:0]  ExpLinSat  = 5'd23;   // v >= 256 always saturates
    localparam logic [14:0] HalfOne    = 15'h3C00;
    localparam logic [7:0]  PixMax     = 8'd255;
    localparam logic [39:0] LinRound   = 40'h0000800000;
    localparam logic [39:0] LinScale   = 40'd255;
    localparam int unsigned CodeLimit  = 15360;   // first code at or above 1.0

    // Exact magnitude of a finite half code, scaled by 2^24.
    function automatic logic [63:0] half_mag(input logic [15:0] h);
        logic [4:0]  ex;
        logic [63:0] fr;
        ex = h[14:10];
        fr = {54'd0, h[9:0]};
        if (ex == 5'd0) begin
            return fr;
        end
        return (fr | 64'h400) << (ex - 5'd1);
    endfunction

    // (m/2^24)^5 >= ((40k+541)/10761)^12, in exact wide integers.
    function automatic logic curve_reaches(input logic [63:0] m, input int unsigned k);
        t_wide lhs;
        t_wide rhs;
        t_wide base;
        lhs  = t_wide'(1);
        rhs  = t_wide'(1);
        base = t_wide'(40 * k + 541);
        for (int i = 0; i < 5; i++) begin
            lhs = lhs * t_wide'(m);
        end
        for (int i = 0; i < 12; i++) begin
            lhs = lhs * t_wide'(10761);
            rhs = rhs * base;
        end
        rhs = rhs << 120;
        return lhs >= rhs;
    endfunction

    // True when the encoded value of code c is at least k.
    function automatic logic code_reaches(input int unsigned c, input int unsigned k);
        logic [63:0] m;
        m = half_mag(16'(c));
        if (m * 64'd10000000 <= (64'd31308 << 24)) begin
            return (64'd32946 * m + (64'd5 << 24)) >= (64'(k) * (64'd10 << 24));
        end
        return curve_reaches(m, k);
    endfunction

    // Smallest non-negative code below 1.0 whose encoding reaches k, per k.
    function automatic t_thr_tab build_thr();
        t_thr_tab    tab;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        tab = '0;
        for (int unsigned k = 1; k < 256; k++) begin
            lo = 0;
            hi = CodeLimit;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (code_reaches(mid, k)) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            tab[k] = 15'(lo);
        end
        return tab;
    endfunction

    localparam t_thr_tab SrgbThr = build_thr();

endpackage

### sv/hrs_lin_quant.sv
// Linear half-float to 8-bit quantiser, rounded half up and saturated.
module hrs_lin_quant (
    input  logic [15:0] i_half,
    output logic [7:0]  o_val
);

    logic [4:0]  ex;
    logic [10:0] mant;
    logic [4:0]  sh;
    logic [31:0] mag;
    logic [39:0] prod;
    logic [15:0] q;

    assign ex   = i_half[14:10];
    assign mant = {(ex != 5'd0), i_half[9:0]};
    assign sh   = (ex == 5'd0) ? 5'd0 : ex - 5'd1;
    assign mag  = 32'(mant) << sh;
    assign prod = 40'(mag) * hrs_pkg::LinScale + hrs_pkg::LinRound;
    assign q    = prod[39:24];

    always_comb begin
        if (ex == hrs_pkg::ExpInfNan) begin
            // NaN and -inf give zero, +inf saturates
            o_val = (i_half[9:0] != 10'd0 || i_half[15]) ? 8'd0 : hrs_pkg::PixMax;
        end else if (i_half[15]) begin
            o_val = 8'd0;
        end else if (ex >= hrs_pkg::ExpLinSat || q > 16'(hrs_pkg::PixMax)) begin
            o_val = hrs_pkg::PixMax;
        end else begin
            o_val = q[7:0];
        end
    end

endmodule

### sv/hrs_srgb_enc.sv
// sRGB curve encoder: compares the half code against the threshold table.
module hrs_srgb_enc (
    input  logic [15:0] i_half,
    output logic [7:0]  o_val
);

    logic [14:0]  code;
    logic [256:0] therm;
    logic [7:0]   bin;

    assign code = i_half[14:0];

    // thermometer: bit k set when the code reaches output level k
    always_comb begin
        therm      = '0;
        therm[0]   = 1'b1;
        for (int k = 1; k < 256; k++) begin
            therm[k] = (code >= hrs_pkg::SrgbThr[k]);
        end
        therm[256] = 1'b0;
    end

    // thermometer to binary: bit j is set in bands starting at odd multiples of 2^j
    always_comb begin
        bin = '0;
        for (int j = 0; j < 8; j++) begin
            for (int m = 1; (m << j) < 256; m += 2) begin
                bin[j] = bin[j] | (therm[m << j] & ~therm[(m + 1) << j]);
            end
        end
    end

    always_comb begin
        if (i_half[15]) begin
            o_val = 8'd0;
        end else if (code >= hrs_pkg::HalfOne) begin
            o_val = hrs_pkg::PixMax;
        end else begin
            o_val = bin;
        end
    end

endmodule

### sv/half_rgba_to_srgb8_pixel_core.sv
// Top level: half-float RGBA pixel to 8-bit pixel with optional sRGB encoding.
// Results pass through the input register and the result register.
// Throughput: one pixel per cycle while the receiver does not stall; the single pass
// through the threshold comparator bank and the linear quantisers sets the clock path.
// Reset (synchronous, active low) empties both stages and selects sRGB mode.
module half_rgba_to_srgb8_pixel_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_red_half,
    input  logic [15:0] i_green_half,
    input  logic [15:0] i_blue_half,
    input  logic [15:0] i_alpha_half,
    input  logic        i_last_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [7:0]  o_alpha_out,
    output logic        o_last_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    logic            r_mode;
    logic            r_in_valid;
    hrs_pkg::t_pix   r_in;
    logic            r_out_valid;
    logic [7:0]      r_red;
    logic [7:0]      r_green;
    logic [7:0]      r_blue;
    logic [7:0]      r_alpha;
    logic            r_last;

    logic            in_acc;
    logic            out_adv;
    logic            n_in_valid;
    logic            n_out_valid;
    logic [7:0]      srgb_r, srgb_g, srgb_b;
    logic [7:0]      lin_r, lin_g, lin_b, lin_a;

    assign o_cfg_ready = 1'b1;

    assign out_adv    = ~r_out_valid | ~i_stall;
    assign o_stall    = r_in_valid & ~out_adv;
    assign in_acc     = i_valid & ~o_stall;
    assign n_in_valid = in_acc | (r_in_valid & ~out_adv);
    assign n_out_valid = out_adv ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= '{red: i_red_half, green: i_green_half, blue: i_blue_half,
                      alpha: i_alpha_half, last: i_last_pixel};
        end
    end

    hrs_srgb_enc u_srgb_r (.i_half(r_in.red),   .o_val(srgb_r));
    hrs_srgb_enc u_srgb_g (.i_half(r_in.green), .o_val(srgb_g));
    hrs_srgb_enc u_srgb_b (.i_half(r_in.blue),  .o_val(srgb_b));

    hrs_lin_quant u_lin_r (.i_half(r_in.red),   .o_val(lin_r));
    hrs_lin_quant u_lin_g (.i_half(r_in.green), .o_val(lin_g));
    hrs_lin_quant u_lin_b (.i_half(r_in.blue),  .o_val(lin_b));
    hrs_lin_quant u_lin_a (.i_half(r_in.alpha), .o_val(lin_a));

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_red   <= r_mode ? srgb_r : lin_r;
            r_green <= r_mode ? srgb_g : lin_g;
            r_blue  <= r_mode ? srgb_b : lin_b;
            r_alpha <= lin_a;
            r_last  <= r_in.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;
    assign o_alpha_out = r_alpha;
    assign o_last_out  = r_last;

endmodule

### sv/hrs_checker.sv
// Port-level checker for the pixel core, bound to the top level.
module hrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_last_pixel,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_red_out,
    input logic [7:0]  o_green_out,
    input logic [7:0]  o_blue_out,
    input logic [7:0]  o_alpha_out,
    input logic        o_last_out
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_red_out) && $stable(o_green_out)
            && $stable(o_blue_out) && $stable(o_alpha_out) && $stable(o_last_out)))
        else $error("stalled result changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    // the core only pushes back when both stages are full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall raised with room downstream");

    // a request with no back-pressure comes out via both registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall |=> (o_valid && o_last_out == $past(i_last_pixel, 2)))
        else $error("request lost or late");

endmodule

bind half_rgba_to_srgb8_pixel_core hrs_checker u_hrs_checker (.*);

### bench/half_rgba_to_srgb8_pixel_core_test.sv
// Self-checking bench for the half-float RGBA to 8-bit pixel core, sRGB and linear modes.
`timescale 1ns / 1ps

module half_rgba_to_srgb8_pixel_core_test;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned HoldCycles = 60;
    localparam int unsigned RandPerPhase = 150;
    localparam int unsigned DirectedPerMode = 12;
    localparam int unsigned ReportLimit = 10;
    localparam logic ModeLinear = 1'b0;
    localparam logic ModeSrgb = 1'b1;

    typedef logic [319:0] t_big;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_px8;

    // Expected 8-bit pixels, predicted on request acceptance
    class pixel_scoreboard;
        logic        srgb_on;
        t_px8        expected_q[$];
        int unsigned mismatches;

        function new();
            srgb_on = ModeSrgb;
            mismatches = 0;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        // |v| * 2^24 for a finite half code
        function logic [63:0] half_magnitude(logic [15:0] h);
            logic [63:0] fr;
            fr = {54'd0, h[9:0]};
            if (h[14:10] == 5'd0) begin
                return fr;
            end
            return (fr | 64'h400) << (h[14:10] - 5'd1);
        endfunction

        // m^5 * 10761^12 >= (40k+541)^12 * 2^120
        function logic curve_at_least(logic [63:0] m, int unsigned k);
            t_big lhs;
            t_big rhs;
            t_big base;
            lhs = t_big'(1);
            rhs = t_big'(1);
            base = t_big'(40 * k + 541);
            for (int i = 0; i < 5; i++) begin
                lhs = lhs * t_big'(m);
            end
            for (int i = 0; i < 12; i++) begin
                lhs = lhs * t_big'(10761);
                rhs = rhs * base;
            end
            rhs = rhs << 120;
            return lhs >= rhs;
        endfunction

        function logic [7:0] srgb_encode(logic [15:0] h);
            logic [63:0] m;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            if (h[15]) begin
                return 8'd0;
            end
            if (h[14:0] >= 15'h3C00) begin
                return 8'd255;
            end
            m = half_magnitude(h);
            if (m * 64'd10000000 <= (64'd31308 << 24)) begin
                return 8'((64'd32946 * m + (64'd5 << 24)) / (64'd10 << 24));
            end
            lo = 0;
            hi = 255;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (curve_at_least(m, mid)) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            return 8'(lo);
        endfunction

        function logic [7:0] lin_quantise(logic [15:0] h);
            logic [63:0] q;
            if (h[14:10] == 5'd31) begin
                // NaN and -inf to zero, +inf saturates
                if (h[9:0] != 10'd0 || h[15]) begin
                    return 8'd0;
                end
                return 8'd255;
            end
            if (h[15]) begin
                return 8'd0;
            end
            q = (half_magnitude(h) * 64'd255 + (64'd1 << 23)) >> 24;
            return (q > 64'd255) ? 8'd255 : q[7:0];
        endfunction

        function void note_request(hrs_pkg::t_pix p);
            t_px8 e;
            if (srgb_on) begin
                e.red = srgb_encode(p.red);
                e.green = srgb_encode(p.green);
                e.blue = srgb_encode(p.blue);
            end else begin
                e.red = lin_quantise(p.red);
                e.green = lin_quantise(p.green);
                e.blue = lin_quantise(p.blue);
            end
            e.alpha = lin_quantise(p.alpha);
            e.last = p.last;
            expected_q.push_back(e);
        endfunction

        function void check_result(t_px8 got);
            t_px8 e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportLimit) begin
                    $display("unexpected result r=%0d g=%0d b=%0d a=%0d l=%0d",
                             got.red, got.green, got.blue, got.alpha, got.last);
                end
                return;
            end
            e = expected_q.pop_front();
            if (got.red !== e.red || got.green !== e.green || got.blue !== e.blue ||
                got.alpha !== e.alpha || got.last !== e.last) begin
                mismatches++;
                if (mismatches <= ReportLimit) begin
                    $display({"mismatch exp r=%0d g=%0d b=%0d a=%0d l=%0d",
                              " got r=%0d g=%0d b=%0d a=%0d l=%0d"},
                             e.red, e.green, e.blue, e.alpha, e.last,
                             got.red, got.green, got.blue, got.alpha, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_red_half = '0;
    logic [15:0] i_green_half = '0;
    logic [15:0] i_blue_half = '0;
    logic [15:0] i_alpha_half = '0;
    logic        i_last_pixel = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    logic [7:0]  o_alpha_out;
    logic        o_last_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    pixel_scoreboard sb;
    int unsigned     cycles = 0;
    int unsigned     sink_wait = 0;
    bit              calm = 1'b0;
    bit              hold_req = 1'b0;
    bit              long_hold = 1'b0;
    logic [15:0]     corner_codes[16];

    half_rgba_to_srgb8_pixel_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red_half   (i_red_half),
        .i_green_half (i_green_half),
        .i_blue_half  (i_blue_half),
        .i_alpha_half (i_alpha_half),
        .i_last_pixel (i_last_pixel),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_alpha_out  (o_alpha_out),
        .o_last_out   (o_last_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check on acceptance, then draw the next stall length
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result({o_red_out, o_green_out, o_blue_out, o_alpha_out, o_last_out});
            sink_wait = calm ? 0 : $urandom_range(0, 3);
        end
    end

    always @(negedge i_clk) begin
        if (long_hold || sink_wait != 0) begin
            i_stall <= 1'b1;
            if (sink_wait != 0) begin
                sink_wait--;
            end
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Long receiver hold-off so the pipe fills and back-pressures the sender
    initial begin
        wait (hold_req);
        long_hold = 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // Called just after a rising edge; leaves valid high after acceptance
    task automatic send_pixel(hrs_pkg::t_pix p, int unsigned gap);
        bit taken;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_red_half <= p.red;
        i_green_half <= p.green;
        i_blue_half <= p.blue;
        i_alpha_half <= p.alpha;
        i_last_pixel <= p.last;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
        end
        sb.note_request(p);
    endtask

    task automatic drain();
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Drops the last request before the pipe drains so it is not taken twice
    task automatic write_mode(logic mode);
        bit taken;
        @(negedge i_clk);
        i_valid <= 1'b0;
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_cfg_ready;
        end
        sb.srgb_on = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return 16'($urandom());
        end
        // codes below one exercise the curve itself
        if (r < 8) begin
            return 16'($urandom_range(0, 16'h3BFF));
        end
        return corner_codes[$urandom_range(0, 15)];
    endfunction

    task automatic directed_set();
        hrs_pkg::t_pix p;
        for (int i = 0; i < DirectedPerMode; i++) begin
            p.red = corner_codes[i];
            p.green = corner_codes[(i + 4) % 16];
            p.blue = corner_codes[(i + 8) % 16];
            p.alpha = corner_codes[(i + 12) % 16];
            p.last = i[0];
            send_pixel(p, $urandom_range(0, 3));
        end
    endtask

    task automatic random_set(bit with_hold);
        hrs_pkg::t_pix p;
        for (int n = 0; n < RandPerPhase; n++) begin
            calm = ((n / 32) % 3) == 2;
            if (with_hold && n == 20) begin
                hold_req = 1'b1;
            end
            p.red = pick_code();
            p.green = pick_code();
            p.blue = pick_code();
            p.alpha = pick_code();
            p.last = 1'($urandom_range(0, 1));
            // no gaps around the hold-off so the input really stalls
            send_pixel(p, (calm || (with_hold && n >= 20 && n < 40)) ? 0 : $urandom_range(0, 3));
        end
        calm = 1'b0;
    endtask

    initial begin
        corner_codes = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF,
                         16'h1A69, 16'h1A6A, 16'h3800, 16'h3BFF,
                         16'h3C00, 16'h5BF8, 16'h5C00, 16'h7BFF,
                         16'h7C00, 16'h7E00, 16'hFC00, 16'hFFFF};
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_set();
        write_mode(ModeLinear);
        directed_set();

        write_mode(ModeSrgb);
        random_set(1'b1);
        write_mode(ModeLinear);
        random_set(1'b0);
        write_mode(ModeSrgb);
        random_set(1'b0);

        @(negedge i_clk);
        i_valid <= 1'b0;
        drain();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
